// ----- hdl/jdg_pkg.sv -----
package jdg_pkg;

    localparam int DAY_NUM_W   = 23;
    localparam int YEAR_W      = 15;
    localparam int MONTH_W     = 4;
    localparam int DOM_W       = 5;
    localparam int PACK_W      = 28;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - YEAR_W - MONTH_W - DOM_W - PACK_W;
    localparam int STAGES      = 9;

    localparam int Q0_W   = 23;
    localparam int CENT_W = 8;
    localparam int Q1_W   = 16;
    localparam int YR4_W  = 7;
    localparam int Q2_W   = 10;
    localparam int MI_W   = 4;
    localparam int OFS_W  = 9;
    localparam int YY_FULL_W = 17;
    localparam int MD_W   = 11;

    localparam logic [DAY_NUM_W-1:0] JDN_MAX  = 23'd5373484;
    localparam logic [Q0_W-1:0]      JDN_BIAS = 23'd68569;

    // floor(a*x/d) as (x*rcp) >> shift, rcp = ceil(a*2^shift/d), exact for x < 2^shift/d
    localparam longint CENT_MUL   = 4;
    localparam longint CENT_DIV   = 146097;
    localparam int     CENT_SHIFT = 41;
    localparam int     CENT_RCP_W = 26;
    localparam logic [CENT_RCP_W-1:0] CENT_RCP =
        CENT_RCP_W'(((CENT_MUL << CENT_SHIFT) + CENT_DIV - 1) / CENT_DIV);

    localparam longint YR_MUL   = 4000;
    localparam longint YR_DIV   = 1461001;
    localparam int     YR_SHIFT = 37;
    localparam int     YR_RCP_W = 29;
    localparam logic [YR_RCP_W-1:0] YR_RCP =
        YR_RCP_W'(((YR_MUL << YR_SHIFT) + YR_DIV - 1) / YR_DIV);

    localparam longint MI_MUL   = 80;
    localparam longint MI_DIV   = 2447;
    localparam int     MI_SHIFT = 22;
    localparam int     MI_RCP_W = 18;
    localparam logic [MI_RCP_W-1:0] MI_RCP =
        MI_RCP_W'(((MI_MUL << MI_SHIFT) + MI_DIV - 1) / MI_DIV);

    localparam logic [CENT_W+2:0]  CENT_DAYS  = 11'd0;
    localparam logic [17:0]        CENT_DAYS4 = 18'd146097;
    localparam logic [10:0]        QUAD_DAYS  = 11'd1461;
    localparam logic [Q2_W-1:0]    MARCH_BIAS = 10'd31;
    localparam logic [MI_W-1:0]    MI_WRAP    = 4'd11;
    localparam logic [MI_W-1:0]    MI_TO_JAN  = 4'd10;
    localparam logic [MI_W-1:0]    MI_TO_MAR  = 4'd2;
    localparam logic [YR4_W-1:0]   CENT_YEARS = 7'd100;
    localparam logic [CENT_W-1:0]  CENT_BASE  = 8'd49;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [MONTH_W-1:0] FEB        = 4'd2;
    localparam logic signed [PACK_W-1:0] PACK_YEAR_SCALE = 28'sd10000;
    localparam logic [MD_W-1:0]    PACK_MONTH_SCALE = 11'd100;
    localparam logic signed [YY_FULL_W-1:0] YY_CENT_SCALE = 17'sd100;

    // (2447*mi)/80, the offset subtracted from the shifted day of year to give the day of month for shifted month mi
    function automatic logic [OFS_W-1:0] month_offset(input logic [MI_W-1:0] mi);
        logic [OFS_W-1:0] ofs;
        case (mi)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd30;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd91;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd152;
            4'd6:    ofs = 9'd183;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd244;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd305;
            4'd11:   ofs = 9'd336;
            4'd12:   ofs = 9'd367;
            4'd13:   ofs = 9'd397;
            4'd14:   ofs = 9'd428;
            4'd15:   ofs = 9'd458;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    function automatic logic [DOM_W-1:0] month_days(input logic [MONTH_W-1:0] mm,
                                                    input logic leap);
        logic [DOM_W-1:0] len;
        case (mm)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            FEB:                                         len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/julian_day_to_gregorian_date.sv -----
// julian day number to gregorian date, nine register stages
// throughput: one date per cycle; a stall on the output side fills bubbles first,
// then holds every stage in place
// reset: rst_n clears the stage valid bits only, the pipeline comes up empty
module julian_day_to_gregorian_date
    import jdg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [22:0] day_number
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [14:0] year, [18:15] month, [23:19] day,
                                              // [51:24] packed_date
    output logic                   m_tuser    // [0] date_valid
);

    logic [STAGES-1:0]        vld_reg;
    logic [STAGES-1:0]        vld_next;
    logic [STAGES-1:0]        en;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         day;
    logic signed [PACK_W-1:0] packed_date;
    logic                     date_valid;

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (!en[i])
                vld_next[i] = vld_reg[i];
            else if (i == 0)
                vld_next[i] = s_tvalid;
            else
                vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    jdg_datapath u_datapath (
        .clk         (clk),
        .en          (en),
        .day_number  (s_tdata[DAY_NUM_W-1:0]),
        .year        (year),
        .month       (month),
        .day         (day),
        .packed_date (packed_date),
        .date_valid  (date_valid)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {OUT_PAD_W'(0), packed_date, day, month, year};
    assign m_tuser  = date_valid;

    a_accept_fills_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_invalid_packs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> packed_date == '0)
        else $error("rejected date with nonzero packed value");

    a_valid_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> month >= MONTH_FIRST && month <= MONTH_LAST
                                && day != '0 && packed_date != '0)
        else $error("valid date with bad month, day or packed value");

    a_stalled_stage_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STAGES-2] && !en[STAGES-2] |=> vld_reg[STAGES-2] && vld_reg[STAGES-1])
        else $error("stalled stage lost its item");

endmodule

// ----- hdl/jdg_datapath.sv -----
module jdg_datapath
    import jdg_pkg::*;
(
    input  logic                        clk,
    input  logic [STAGES-1:0]           en,
    input  logic [DAY_NUM_W-1:0]        day_number,
    output logic signed [YEAR_W-1:0]    year,
    output logic [MONTH_W-1:0]          month,
    output logic [DOM_W-1:0]            day,
    output logic signed [PACK_W-1:0]    packed_date,
    output logic                        date_valid
);

    // stage 1: bias and range check
    logic                    s1_inr_reg;
    logic [Q0_W-1:0]         s1_q0_reg;
    logic                    s1_inr_next;
    logic [Q0_W-1:0]         s1_q0_next;

    // stage 2: century estimate
    logic                    s2_inr_reg;
    logic [Q0_W-1:0]         s2_q0_reg;
    logic [CENT_W-1:0]       s2_cent_reg;
    logic [Q0_W+CENT_RCP_W-1:0] s2_prod;
    logic [CENT_W-1:0]       s2_cent_next;

    // stage 3: days within century
    logic                    s3_inr_reg;
    logic [CENT_W-1:0]       s3_cent_reg;
    logic [Q1_W-1:0]         s3_q1_reg;
    logic [Q0_W+1:0]         s3_sub;
    logic [Q1_W-1:0]         s3_q1_next;

    // stage 4: year within century
    logic                    s4_inr_reg;
    logic [CENT_W-1:0]       s4_cent_reg;
    logic [Q1_W-1:0]         s4_q1_reg;
    logic [YR4_W-1:0]        s4_yr4_reg;
    logic [Q1_W+YR_RCP_W-1:0] s4_prod;
    logic [YR4_W-1:0]        s4_yr4_next;

    // stage 5: day of shifted year
    logic                    s5_inr_reg;
    logic [CENT_W-1:0]       s5_cent_reg;
    logic [YR4_W-1:0]        s5_yr4_reg;
    logic [Q2_W-1:0]         s5_q2_reg;
    logic [17:0]             s5_sub;
    logic [Q2_W-1:0]         s5_q2_next;

    // stage 6: shifted month
    logic                    s6_inr_reg;
    logic [CENT_W-1:0]       s6_cent_reg;
    logic [YR4_W-1:0]        s6_yr4_reg;
    logic [Q2_W-1:0]         s6_q2_reg;
    logic [MI_W-1:0]         s6_mi_reg;
    logic [Q2_W+MI_RCP_W-1:0] s6_prod;
    logic [MI_W-1:0]         s6_mi_next;

    // stage 7: calendar fields and leap flag
    logic                    s7_inr_reg;
    logic signed [YEAR_W-1:0] s7_yy_reg;
    logic [MONTH_W-1:0]      s7_mm_reg;
    logic [DOM_W-1:0]        s7_dd_reg;
    logic                    s7_leap_reg;
    logic                    s7_carry;
    logic [YR4_W-1:0]        s7_r;
    logic [1:0]              s7_c100_lo;
    logic [Q2_W-1:0]         s7_dd_full;
    logic signed [YY_FULL_W-1:0] s7_yy_full;
    logic signed [YEAR_W-1:0] s7_yy_next;
    logic [MONTH_W-1:0]      s7_mm_next;
    logic [DOM_W-1:0]        s7_dd_next;
    logic                    s7_leap_next;

    // stage 8: check and year scaling
    logic                    s8_inr_reg;
    logic signed [YEAR_W-1:0] s8_yy_reg;
    logic [MONTH_W-1:0]      s8_mm_reg;
    logic [DOM_W-1:0]        s8_dd_reg;
    logic                    s8_ok_reg;
    logic signed [PACK_W-1:0] s8_yy10k_reg;
    logic                    s8_ok_next;
    logic signed [PACK_W-1:0] s8_yy10k_next;

    // stage 9: output register
    logic signed [YEAR_W-1:0] out_year_reg;
    logic [MONTH_W-1:0]      out_month_reg;
    logic [DOM_W-1:0]        out_day_reg;
    logic signed [PACK_W-1:0] out_packed_reg;
    logic                    out_valid_reg;
    logic [MD_W-1:0]         s9_md;
    logic signed [YEAR_W-1:0] out_year_next;
    logic [MONTH_W-1:0]      out_month_next;
    logic [DOM_W-1:0]        out_day_next;
    logic signed [PACK_W-1:0] out_packed_next;
    logic                    out_valid_next;

    always_comb
    begin
        s1_inr_next = (day_number <= JDN_MAX);
        s1_q0_next  = Q0_W'(day_number + JDN_BIAS);

        s2_prod      = (Q0_W+CENT_RCP_W)'(s1_q0_reg) * (Q0_W+CENT_RCP_W)'(CENT_RCP);
        s2_cent_next = s2_prod[CENT_SHIFT+CENT_W-1:CENT_SHIFT];

        s3_sub     = ((Q0_W+2)'(s2_cent_reg) * (Q0_W+2)'(CENT_DAYS4) + (Q0_W+2)'(3)) >> 2;
        s3_q1_next = Q1_W'((Q0_W+2)'(s2_q0_reg) - s3_sub);

        s4_prod     = (Q1_W+YR_RCP_W)'(Q1_W'(s3_q1_reg + Q1_W'(1)))
                      * (Q1_W+YR_RCP_W)'(YR_RCP);
        s4_yr4_next = s4_prod[YR_SHIFT+YR4_W-1:YR_SHIFT];

        s5_sub     = (18'(s4_yr4_reg) * 18'(QUAD_DAYS)) >> 2;
        s5_q2_next = Q2_W'(18'(s4_q1_reg) + 18'(MARCH_BIAS) - s5_sub);

        s6_prod    = (Q2_W+MI_RCP_W)'(s5_q2_reg) * (Q2_W+MI_RCP_W)'(MI_RCP);
        s6_mi_next = s6_prod[MI_SHIFT+MI_W-1:MI_SHIFT];

        s7_carry     = (s6_mi_reg >= MI_WRAP);
        s7_dd_full   = s6_q2_reg - Q2_W'(month_offset(s6_mi_reg));
        s7_dd_next   = s7_dd_full[DOM_W-1:0];
        s7_mm_next   = s7_carry ? MONTH_W'(s6_mi_reg - MI_TO_JAN)
                                : MONTH_W'(s6_mi_reg + MI_TO_MAR);
        s7_r         = s6_yr4_reg + YR4_W'(s7_carry);
        s7_yy_full   = YY_CENT_SCALE
                       * ($signed(YY_FULL_W'(s6_cent_reg)) - $signed(YY_FULL_W'(CENT_BASE)))
                       + $signed(YY_FULL_W'(s7_r));
        s7_yy_next   = s7_yy_full[YEAR_W-1:0];
        // century years are leap only when the century count is a multiple of four
        s7_c100_lo   = s6_cent_reg[1:0] - CENT_BASE[1:0] + 2'(s7_r == CENT_YEARS);
        s7_leap_next = (s7_r[1:0] == 2'd0)
                       && (((s7_r != '0) && (s7_r != CENT_YEARS)) || (s7_c100_lo == 2'd0));

        s8_ok_next    = (s7_mm_reg >= MONTH_FIRST) && (s7_mm_reg <= MONTH_LAST)
                        && (s7_dd_reg != '0)
                        && (s7_dd_reg <= month_days(s7_mm_reg, s7_leap_reg));
        s8_yy10k_next = PACK_W'($signed({{(PACK_W-YEAR_W){s7_yy_reg[YEAR_W-1]}}, s7_yy_reg})
                                * PACK_YEAR_SCALE);

        s9_md = MD_W'(s8_mm_reg) * PACK_MONTH_SCALE + MD_W'(s8_dd_reg);
        if (s8_inr_reg)
        begin
            out_year_next   = s8_yy_reg;
            out_month_next  = s8_mm_reg;
            out_day_next    = s8_dd_reg;
            out_valid_next  = s8_ok_reg;
            out_packed_next = s8_ok_reg ? s8_yy10k_reg + $signed(PACK_W'(s9_md)) : '0;
        end
        else
        begin
            out_year_next   = '0;
            out_month_next  = '0;
            out_day_next    = '0;
            out_valid_next  = 1'b0;
            out_packed_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_inr_reg <= s1_inr_next;
            s1_q0_reg  <= s1_q0_next;
        end
        if (en[1])
        begin
            s2_inr_reg  <= s1_inr_reg;
            s2_q0_reg   <= s1_q0_reg;
            s2_cent_reg <= s2_cent_next;
        end
        if (en[2])
        begin
            s3_inr_reg  <= s2_inr_reg;
            s3_cent_reg <= s2_cent_reg;
            s3_q1_reg   <= s3_q1_next;
        end
        if (en[3])
        begin
            s4_inr_reg  <= s3_inr_reg;
            s4_cent_reg <= s3_cent_reg;
            s4_q1_reg   <= s3_q1_reg;
            s4_yr4_reg  <= s4_yr4_next;
        end
        if (en[4])
        begin
            s5_inr_reg  <= s4_inr_reg;
            s5_cent_reg <= s4_cent_reg;
            s5_yr4_reg  <= s4_yr4_reg;
            s5_q2_reg   <= s5_q2_next;
        end
        if (en[5])
        begin
            s6_inr_reg  <= s5_inr_reg;
            s6_cent_reg <= s5_cent_reg;
            s6_yr4_reg  <= s5_yr4_reg;
            s6_q2_reg   <= s5_q2_reg;
            s6_mi_reg   <= s6_mi_next;
        end
        if (en[6])
        begin
            s7_inr_reg  <= s6_inr_reg;
            s7_yy_reg   <= s7_yy_next;
            s7_mm_reg   <= s7_mm_next;
            s7_dd_reg   <= s7_dd_next;
            s7_leap_reg <= s7_leap_next;
        end
        if (en[7])
        begin
            s8_inr_reg   <= s7_inr_reg;
            s8_yy_reg    <= s7_yy_reg;
            s8_mm_reg    <= s7_mm_reg;
            s8_dd_reg    <= s7_dd_reg;
            s8_ok_reg    <= s8_ok_next;
            s8_yy10k_reg <= s8_yy10k_next;
        end
        if (en[8])
        begin
            out_year_reg   <= out_year_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            out_packed_reg <= out_packed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign year        = out_year_reg;
    assign month       = out_month_reg;
    assign day         = out_day_reg;
    assign packed_date = out_packed_reg;
    assign date_valid  = out_valid_reg;

endmodule

// ----- verif/jdn_date_checker.sv -----
module jdn_date_checker
    import jdg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [22:0] day_number
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [14:0] year, [18:15] month, [23:19] day,
                                              // [51:24] packed_date
    input  logic                   m_tuser,   // [0] date_valid
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic signed [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0]        month;
        logic [DOM_W-1:0]          dom;
        logic signed [PACK_W-1:0]  packed_date;
        logic                      valid;
    } greg_date_t;

    greg_date_t dates_due[$];

    function automatic logic is_leap(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic greg_date_t gregorian_of(input logic [DAY_NUM_W-1:0] jdn);
        longint q;
        longint cent;
        longint yr4;
        longint mi;
        longint carry;
        longint dd;
        longint mm;
        longint yy;
        longint len;
        longint pk;
        logic ok;
        greg_date_t r;
        r = '0;
        if (jdn > JDN_MAX)
        begin
            return r;
        end
        q     = longint'(jdn) + 68569;
        cent  = (4 * q) / 146097;
        q     = q - (146097 * cent + 3) / 4;
        yr4   = (4000 * (q + 1)) / 1461001;
        q     = q - ((1461 * yr4) / 4 - 31);
        mi    = (80 * q) / 2447;
        carry = mi / 11;
        dd    = q - (2447 * mi) / 80;
        mm    = mi + 2 - 12 * carry;
        yy    = 100 * (cent - 49) + yr4 + carry;
        case (mm)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(yy) ? 29 : 28;
            default:               len = 0;
        endcase
        ok = (mm >= 1) && (mm <= 12) && (dd >= 1) && (dd <= len);
        pk = ok ? (yy * 100 + mm) * 100 + dd : 0;
        r.year        = yy[YEAR_W-1:0];
        r.month       = mm[MONTH_W-1:0];
        r.dom         = dd[DOM_W-1:0];
        r.packed_date = pk[PACK_W-1:0];
        r.valid       = ok;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        greg_date_t want;
        greg_date_t got;
        if (!rst_n)
        begin
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                dates_due.push_back(gregorian_of(s_tdata[DAY_NUM_W-1:0]));
            end
            if (m_tvalid && m_tready)
            begin
                got.year        = m_tdata[14:0];
                got.month       = m_tdata[18:15];
                got.dom         = m_tdata[23:19];
                got.packed_date = m_tdata[51:24];
                got.valid       = m_tuser;
                if (dates_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = dates_due.pop_front();
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day", want.dom, got.dom);
                    check_field("packed_date", want.packed_date, got.packed_date);
                    check_field("date_valid", want.valid, got.valid);
                end
            end
            pending <= dates_due.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    import jdg_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_DAY     = (1 << DAY_NUM_W) - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    int                     errors;
    int                     pending;
    int                     cycle_count;
    logic                   send_burst;
    logic                   recv_burst;

    julian_day_to_gregorian_date u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    jdn_date_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_day(input int day);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(day);
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // receiver: random stall before each output transfer, none while in a burst
    initial
    begin
        int hold;
        m_tready   = 1'b0;
        recv_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                recv_burst = ~recv_burst;
            end
            hold = recv_burst ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        int edge_days[$];
        int sel;
        int day;
        edge_days = '{0, 1, 2, int'(JDN_MAX) - 1, int'(JDN_MAX), int'(JDN_MAX) + 1, MAX_DAY,
                      1721059, 1721060, 2415079, 2415080, 2451544, 2451545,
                      2451604, 2451605, 2440588, 4194303, 4194304, 2299160,
                      2299161, 3000000, 1000000};
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        send_burst = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_days[i])
        begin
            send_day(edge_days[i]);
        end

        for (int i = 0; i < 800; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                day = $urandom_range(0, JDN_MAX);
            end
            else if (sel < 88)
            begin
                day = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                           : JDN_MAX - 3 + $urandom_range(0, 7);
            end
            else
            begin
                day = $urandom_range(JDN_MAX + 1, MAX_DAY);
            end
            send_day(day);
        end
        s_tvalid <= 1'b0;

        // drain
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (30) @(posedge clk);

        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
